// ----- hw/rtl/abm_pkg.sv -----
// abm_pkg: shared types, constants and helpers for the adjacency bit matrix block
// no dependencies; compiled before every other file of the block
`default_nettype none

package abm_pkg;

  // matrix geometry
  localparam int MAX_NODES = 64;
  localparam int ROW_AW    = $clog2(MAX_NODES);

  // field widths fixed by the item layout
  localparam int FUNC_W = 3;
  localparam int NODE_W = 6;
  localparam int CNT_W  = 7;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_NODE_COUNT = '0;
  localparam logic [CNT_W-1:0]  NODE_COUNT_RST = CNT_W'(MAX_NODES);

  // operation codes of the func field
  localparam logic [FUNC_W-1:0] FN_INIT   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_LIST   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_LOWER  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_COUNT  = 3'd4;

  // classified command kinds
  typedef enum logic [2:0] {
    K_INIT,
    K_DELETE,
    K_LIST,
    K_LOWER,
    K_COUNT,
    K_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              skip;
    logic [CNT_W-1:0]  lim;
  } cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] count;
    logic              empty_res;
    logic              bad_index;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
  } apb_req_t;

  // back end sequencer
  typedef enum logic [2:0] {
    BS_IDLE,
    BS_DEL_A,
    BS_DEL_B,
    BS_LOAD,
    BS_SCAN
  } back_state_t;

  // row of the complete graph: all ones but the diagonal
  function automatic logic [MAX_NODES-1:0] reset_row(input logic [ROW_AW-1:0] r);
    logic [MAX_NODES-1:0] row;
    row    = '1;
    row[r] = 1'b0;
    return row;
  endfunction

  // single bit mask for one node
  function automatic logic [MAX_NODES-1:0] node_bit(input logic [ROW_AW-1:0] r);
    logic [MAX_NODES-1:0] m;
    m    = '0;
    m[r] = 1'b1;
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/abm_in_if.sv -----
// abm_in_if: operation channel carrying one command beat with valid/ready
// depends on abm_pkg for field widths
`default_nettype none

interface abm_in_if import abm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  logic              skip_enable;

  modport source (output valid, func, node_a, node_b, skip_enable, input ready);
  modport sink   (input valid, func, node_a, node_b, skip_enable, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/abm_out_if.sv -----
// abm_out_if: result channel carrying one result beat with valid/ready
// depends on abm_pkg for field widths
`default_nettype none

interface abm_out_if import abm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] node;
  logic [NODE_W-1:0] count;
  logic              empty_res;
  logic              bad_index;
  logic              last;

  modport source (output valid, node, count, empty_res, bad_index, last, input ready);
  modport sink   (input valid, node, count, empty_res, bad_index, last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/undirected_adjacency_bit_matrix.sv -----
// undirected_adjacency_bit_matrix: top level joining intake, command queue and executor
// depends on abm_pkg, abm_in_if, abm_out_if, abm_front, abm_queue, abm_back
//
//   channel | dir | handshake              | beat
//   in_ch   | in  | valid/ready            | func, node_a, node_b, skip_enable
//   out_ch  | out | valid/ready            | node, count, empty_res, bad_index, last
//   cfg_*   | in  | apb, pready tied high  | node_count at byte address 0
//
// init and refused operations finish in the executor's idle state; delete does two
// row read-modify-writes through the single memory port; list, lower and count load
// the row, then scan it one bit per cycle unless the result register stalls, up to
// lim (lim is node_count, or node_a for lower edges). unused codes are taken from the
// channel and dropped by the intake. reset is synchronous: row flags make the matrix
// read as the complete graph at once, so there is no clearing pass.
// a 2-deep command queue and a result register let intake and output stall apart.
`default_nettype none

module undirected_adjacency_bit_matrix import abm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  abm_in_if.sink            in_ch,
  abm_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  apb_req_t apb;
  cmd_t     push_cmd;
  logic     push;
  logic     q_full;
  cmd_t     head;
  logic     head_valid;
  logic     pop;

  // configuration request bundle
  assign apb.psel    = cfg_psel;
  assign apb.penable = cfg_penable;
  assign apb.pwrite  = cfg_pwrite;
  assign apb.paddr   = cfg_paddr;
  assign apb.pwdata  = cfg_pwdata;
  assign cfg_pready  = 1'b1;

  abm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .apb      (apb),
    .prdata   (cfg_prdata),
    .cmd      (push_cmd),
    .cmd_push (push),
    .q_full   (q_full)
  );

  abm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cmd   (push_cmd),
    .push       (push),
    .full       (q_full),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  abm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (head),
    .cmd_valid (head_valid),
    .cmd_pop   (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/abm_front.sv -----
// abm_front: node count register, command intake and classification
// depends on abm_pkg and abm_in_if
`default_nettype none

module abm_front import abm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  abm_in_if.sink            in_ch,
  input  apb_req_t          apb,
  output logic [APB_DW-1:0] prdata,
  output cmd_t              cmd,
  output logic              cmd_push,
  input  logic              q_full
);

  logic [CNT_W-1:0] node_count_r;
  logic [CNT_W-1:0] n_use;
  logic             reg_sel;
  logic             a_ok;
  logic             b_ok;
  logic             known;

  // register decode
  assign reg_sel = (apb.paddr[APB_AW-1:2] == REG_NODE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (apb.psel && apb.penable && apb.pwrite && reg_sel) begin
      node_count_r <= apb.pwdata[CNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(APB_DW-CNT_W){1'b0}}, node_count_r} : '0;

  // clamp into 1..MAX_NODES
  always_comb begin
    priority if (node_count_r == '0) begin
      n_use = CNT_W'(1);
    end else if (node_count_r > CNT_W'(MAX_NODES)) begin
      n_use = CNT_W'(MAX_NODES);
    end else begin
      n_use = node_count_r;
    end
  end

  assign a_ok = ({1'b0, in_ch.node_a} < n_use);
  assign b_ok = ({1'b0, in_ch.node_b} < n_use);

  // classify the beat into a back end command
  always_comb begin
    cmd.kind   = K_INIT;
    cmd.node_a = in_ch.node_a;
    cmd.node_b = in_ch.node_b;
    cmd.skip   = 1'b0;
    cmd.lim    = n_use;
    known      = 1'b1;
    unique case (in_ch.func)
      FN_INIT: begin
        cmd.kind = K_INIT;
      end
      FN_DELETE: begin
        cmd.kind = (a_ok && b_ok) ? K_DELETE : K_BAD;
      end
      FN_LIST: begin
        cmd.kind = a_ok ? K_LIST : K_BAD;
        cmd.skip = in_ch.skip_enable;
      end
      FN_LOWER: begin
        cmd.kind = a_ok ? K_LOWER : K_BAD;
        cmd.lim  = {1'b0, in_ch.node_a};
      end
      FN_COUNT: begin
        cmd.kind = a_ok ? K_COUNT : K_BAD;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unused codes are taken and dropped
  assign in_ch.ready = !q_full;
  assign cmd_push    = in_ch.valid && !q_full && known;

endmodule

`default_nettype wire

// ----- hw/rtl/abm_queue.sv -----
// abm_queue: short command queue decoupling intake from execution
// depends on abm_pkg
`default_nettype none

module abm_queue import abm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t push_cmd,
  input  logic push,
  output logic full,
  output cmd_t head,
  output logic head_valid,
  input  logic pop
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] fill_r;
  logic              do_push;
  logic              do_pop;

  assign full       = (fill_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/abm_back.sv -----
// abm_back: matrix memory, command sequencer, row scanner and result register
// depends on abm_pkg and abm_out_if
`default_nettype none

module abm_back import abm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cmd_t     cmd,
  input  logic     cmd_valid,
  output logic     cmd_pop,
  abm_out_if.source out_ch
);

  // matrix storage, one row per node
  logic [MAX_NODES-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_vld_r;
  logic [MAX_NODES-1:0] mem_q_r;
  logic                 rd_vld_r;
  logic [ROW_AW-1:0]    rd_addr_r;
  logic [MAX_NODES-1:0] row_eff;

  logic                 rd_en;
  logic [ROW_AW-1:0]    rd_addr;
  logic                 wr_en;
  logic [ROW_AW-1:0]    wr_addr;
  logic [MAX_NODES-1:0] wr_data;
  logic                 clr_vld;

  // sequencer and scan state
  back_state_t          state_r, state_nxt;
  cmd_t                 cur_r, cur_nxt;
  logic [MAX_NODES-1:0] row_r, row_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [NODE_W-1:0]    pend_node_r, pend_node_nxt;
  logic [NODE_W-1:0]    cnt_r, cnt_nxt;
  result_t              out_r;
  logic                 out_valid_r;

  logic                 can_emit;
  logic                 emit;
  result_t              emit_res;
  logic                 start;
  logic                 scan_end;
  logic                 hit;
  logic                 stall;

  // memory port: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r   <= mem[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // row written flags: a row never written reads as the complete graph
  always_ff @(posedge clk) begin
    if (!rst_n || clr_vld) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  assign row_eff = rd_vld_r ? mem_q_r : reset_row(rd_addr_r);

  // shared conditions
  assign can_emit = !out_valid_r || out_ch.ready;
  assign start    = cmd_valid &&
                    (((cmd.kind != K_INIT) && (cmd.kind != K_BAD)) || can_emit);
  assign scan_end = (idx_r == cur_r.lim);
  assign hit      = row_r[0] && (idx_r[NODE_W-1:0] != cur_r.node_a) &&
                    !(cur_r.skip && (idx_r[NODE_W-1:0] == cur_r.node_b));
  assign stall    = !can_emit &&
                    (scan_end || (hit && pend_v_r && (cur_r.kind != K_COUNT)));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE: begin
        if (start) begin
          unique case (cmd.kind)
            K_DELETE:                 state_nxt = BS_DEL_A;
            K_LIST, K_LOWER, K_COUNT: state_nxt = BS_LOAD;
            default:                  state_nxt = BS_IDLE;
          endcase
        end
      end
      BS_DEL_A: state_nxt = BS_DEL_B;
      BS_DEL_B: state_nxt = BS_IDLE;
      BS_LOAD:  state_nxt = BS_SCAN;
      BS_SCAN: begin
        if (scan_end && can_emit) begin
          state_nxt = BS_IDLE;
        end
      end
      default:  state_nxt = BS_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_pop       = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = cur_r.node_a[ROW_AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = cur_r.node_a[ROW_AW-1:0];
    wr_data       = row_eff;
    clr_vld       = 1'b0;
    emit          = 1'b0;
    emit_res      = '0;
    cur_nxt       = cur_r;
    row_nxt       = row_r;
    idx_nxt       = idx_r;
    pend_v_nxt    = pend_v_r;
    pend_node_nxt = pend_node_r;
    cnt_nxt       = cnt_r;
    unique case (state_r)
      BS_IDLE: begin
        if (start) begin
          cmd_pop = 1'b1;
          cur_nxt = cmd;
          rd_addr = cmd.node_a[ROW_AW-1:0];
          unique case (cmd.kind)
            K_INIT: begin
              clr_vld       = 1'b1;
              emit          = 1'b1;
              emit_res.last = 1'b1;
            end
            K_BAD: begin
              emit               = 1'b1;
              emit_res.bad_index = 1'b1;
              emit_res.last      = 1'b1;
            end
            default: begin
              rd_en = 1'b1;
            end
          endcase
        end
      end
      // row a has arrived: clear bit b, fetch row b
      BS_DEL_A: begin
        wr_en   = 1'b1;
        wr_addr = cur_r.node_a[ROW_AW-1:0];
        wr_data = row_eff & ~node_bit(cur_r.node_b[ROW_AW-1:0]);
        rd_en   = 1'b1;
        rd_addr = cur_r.node_b[ROW_AW-1:0];
      end
      BS_DEL_B: begin
        wr_en   = 1'b1;
        wr_addr = cur_r.node_b[ROW_AW-1:0];
        wr_data = row_eff & ~node_bit(cur_r.node_a[ROW_AW-1:0]);
      end
      BS_LOAD: begin
        row_nxt    = row_eff;
        idx_nxt    = '0;
        pend_v_nxt = 1'b0;
        cnt_nxt    = '0;
      end
      // one bit per cycle when not stalled; a found node waits until the next one decides last
      BS_SCAN: begin
        if (!stall) begin
          if (scan_end) begin
            emit          = 1'b1;
            emit_res.last = 1'b1;
            if (cur_r.kind == K_COUNT) begin
              emit_res.count = cnt_r;
            end else if (pend_v_r) begin
              emit_res.node = pend_node_r;
            end else begin
              emit_res.empty_res = 1'b1;
            end
          end else begin
            row_nxt = row_r >> 1;
            idx_nxt = idx_r + 1'b1;
            if (hit) begin
              if (cur_r.kind == K_COUNT) begin
                cnt_nxt = cnt_r + 1'b1;
              end else begin
                if (pend_v_r) begin
                  emit          = 1'b1;
                  emit_res.node = pend_node_r;
                end
                pend_v_nxt    = 1'b1;
                pend_node_nxt = idx_r[NODE_W-1:0];
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    row_r       <= row_nxt;
    idx_r       <= idx_nxt;
    pend_node_r <= pend_node_nxt;
    cnt_r       <= cnt_nxt;
    if (emit) begin
      out_r <= emit_res;
    end
  end

  // result channel
  assign out_ch.valid     = out_valid_r;
  assign out_ch.node      = out_r.node;
  assign out_ch.count     = out_r.count;
  assign out_ch.empty_res = out_r.empty_res;
  assign out_ch.bad_index = out_r.bad_index;
  assign out_ch.last      = out_r.last;

endmodule

`default_nettype wire

// ----- hw/rtl/abm_checker.sv -----
// abm_checker: port-level checks on the result channel of the matrix block
// depends on abm_pkg; attached to the top level by the bind at the end of this file
`default_nettype none

module abm_checker import abm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [NODE_W-1:0] out_node,
  input logic [NODE_W-1:0] out_count,
  input logic              out_empty,
  input logic              out_bad,
  input logic              out_last
);

  // a stalled beat stays
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled beat keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_node) && $stable(out_count) &&
    $stable(out_empty) && $stable(out_bad) && $stable(out_last))
    else $error("result payload changed while stalled");

  // a refused operation gives a lone closing beat with nothing else set
  a_bad_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad |-> out_last && !out_empty && out_node == '0 &&
    out_count == '0)
    else $error("bad index beat malformed");

  // an empty list closes the item and names no node
  a_empty_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty |-> out_last && !out_bad && out_node == '0 &&
    out_count == '0)
    else $error("empty list beat malformed");

  // a neighbour total only ever comes on a closing beat with node zero
  a_count_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count != '0 |-> out_last && out_node == '0)
    else $error("count beat malformed");

endmodule

bind undirected_adjacency_bit_matrix abm_checker u_abm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_node  (out_ch.node),
  .out_count (out_ch.count),
  .out_empty (out_ch.empty_res),
  .out_bad   (out_ch.bad_index),
  .out_last  (out_ch.last)
);

`default_nettype wire
